FILE: rtl/tcq_pkg.sv
package tcq_pkg;

  localparam int unsigned CHANNELS_DEF = 2;

  localparam int unsigned STALE_W = 14;
  localparam int unsigned TICK_W = 10;
  localparam int unsigned MINP_W = 20;
  localparam int unsigned PPR_W = 8;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned GAIN_FRAC_W = 8;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned PER_W = 24;
  localparam int unsigned RPM_W = 16;
  localparam int unsigned CLEAN_W = 2;

  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_STALE_MS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_US = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD_US = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN_Q8 = 3'd4;

  localparam logic [STALE_W-1:0] STALE_MS_RST = 14'd500;
  localparam logic [TICK_W-1:0] TICK_US_RST = 10'd10;
  localparam logic [MINP_W-1:0] MIN_PERIOD_US_RST = 20'd200;
  localparam logic [PPR_W-1:0] PULSES_PER_REV_RST = 8'd1;
  localparam logic [GAIN_W-1:0] CAL_GAIN_Q8_RST = 16'd256;

  localparam logic MODE_EDGE = 1'b0;

  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned RPM_SCALE = 60000000;
  localparam int unsigned CLEAN_FULL = 2;

  localparam int unsigned STALE_US_W = 24;
  localparam int unsigned PROD_W = TIME_W + TICK_W;
  localparam int unsigned NUM_W = 26 + GAIN_W;
  localparam int unsigned DEN_W = PER_W + PPR_W + GAIN_FRAC_W;
  localparam int unsigned STEP_W = $clog2(RPM_W);

  typedef struct packed {
    logic [STALE_W-1:0] stale_ms;
    logic [TICK_W-1:0]  tick_us;
    logic [MINP_W-1:0]  min_period_us;
    logic [PPR_W-1:0]   pulses_per_rev;
    logic [GAIN_W-1:0]  cal_gain_q8;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic edge_a;
    logic edge_b;
    logic rep_a;
    logic rep_b;
    logic sat_chk;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic edge_item;
    logic fresh;
    logic sat;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/tach_capture_qualifier_rpm_top.sv
// Per-channel tachometer period capture with qualification and RPM readout. Each input
// transaction is either a capture edge (tuser 0) or a status query (tuser 1) and returns
// exactly one status transaction. An edge after a stale baseline only sets a new baseline,
// a period shorter than min_period_us counts as a glitch, and two clean periods in a row
// are needed before a period is published. RPM is computed by a 16-step restoring divider
// with saturation at 65535. Items are processed one at a time: an edge first updates its
// channel's baseline and qualification, which a query skips, then both build the report;
// a fresh result adds a saturation check and, unless saturated, the divider iterations.
// The next item is accepted as soon as the result sits in the output register, so a
// stalled output costs nothing until a second result is ready.
// Configuration writes are always accepted and should be issued only while idle.
module tach_capture_qualifier_rpm_top #(
  parameter int unsigned CHANNELS = tcq_pkg::CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0: channel, capture_value, now_ms, zero padding.
  input  logic [tcq_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // Fields from bit 0: mode.
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: fresh, rpm, period_out_us, recent_activity, edge_count,
  // glitch_count, zero padding.
  output logic [tcq_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tcq_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tcq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcq_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_mode_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: rtl/tcq_cfg.sv
module tcq_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tcq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tcq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output tcq_pkg::cfg_t                    cfg_o
);
  import tcq_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_ms       <= STALE_MS_RST;
      cfg_q.tick_us        <= TICK_US_RST;
      cfg_q.min_period_us  <= MIN_PERIOD_US_RST;
      cfg_q.pulses_per_rev <= PULSES_PER_REV_RST;
      cfg_q.cal_gain_q8    <= CAL_GAIN_Q8_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STALE_MS:       cfg_q.stale_ms       <= cfg_data_i[STALE_W-1:0];
        REG_TICK_US:        cfg_q.tick_us        <= cfg_data_i[TICK_W-1:0];
        REG_MIN_PERIOD_US:  cfg_q.min_period_us  <= cfg_data_i[MINP_W-1:0];
        REG_PULSES_PER_REV: cfg_q.pulses_per_rev <= cfg_data_i[PPR_W-1:0];
        REG_CAL_GAIN_Q8:    cfg_q.cal_gain_q8    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/tcq_ctrl.sv
module tcq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tcq_pkg::sts_t sts_i,
  output tcq_pkg::cmd_t cmd_o
);
  import tcq_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_EDGE_A = 8'b0000_0010,
    ST_EDGE_B = 8'b0000_0100,
    ST_REP_A  = 8'b0000_1000,
    ST_REP_B  = 8'b0001_0000,
    ST_SAT    = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = ST_EDGE_A;
        end
      end
      ST_EDGE_A: begin
        cmd_o.edge_a = 1'b1;
        state_d = sts_i.edge_item ? ST_EDGE_B : ST_REP_A;
      end
      ST_EDGE_B: begin
        cmd_o.edge_b = 1'b1;
        state_d = ST_REP_A;
      end
      ST_REP_A: begin
        cmd_o.rep_a = 1'b1;
        state_d = ST_REP_B;
      end
      ST_REP_B: begin
        if (sts_i.fresh) begin
          cmd_o.rep_b = 1'b1;
          state_d = ST_SAT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SAT: begin
        cmd_o.sat_chk = 1'b1;
        step_d = '0;
        state_d = sts_i.sat ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(RPM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/tcq_dp.sv
module tcq_dp #(
  parameter int unsigned CHANNELS = tcq_pkg::CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcq_pkg::cfg_t                  cfg_i,
  input  tcq_pkg::cmd_t                  cmd_i,
  output tcq_pkg::sts_t                  sts_o,
  input  logic [tcq_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                           in_mode_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tcq_pkg::OUT_DATA_W-1:0] out_data_o
);
  import tcq_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned WIDE_W = DEN_W + RPM_W;
  localparam int unsigned DSH_W = DEN_W + RPM_W - 1;
  localparam int unsigned OUT_PAD_W = OUT_DATA_W - (2 + RPM_W + PER_W + 2 * CNT_W);
  localparam int unsigned MUL_W = PER_W + PPR_W;

  logic              mode_q;
  logic              ch_q;
  logic [TIME_W-1:0] cap_q;
  logic [TIME_W-1:0] now_q;

  logic [TIME_W-1:0]  prev_cap_q [CHANNELS];
  logic [TIME_W-1:0]  prev_ms_q  [CHANNELS];
  logic [PER_W-1:0]   per_q      [CHANNELS];
  logic [TIME_W-1:0]  vstamp_q   [CHANNELS];
  logic [CLEAN_W-1:0] clean_q    [CHANNELS];
  logic [CHANNELS-1:0] seen_q;
  logic [CNT_W-1:0]   edges_q    [CHANNELS];
  logic [CNT_W-1:0]   glit_q     [CHANNELS];

  logic [TIME_W-1:0] ticks_q;
  logic [TIME_W-1:0] age_q;
  logic              first_q;

  logic                fresh_q;
  logic [CHANNELS-1:0] act_q;
  logic [PER_W-1:0]    age_us_q;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    den_q;
  logic                sat_q;
  logic [NUM_W-1:0]    rem_q;
  logic [DSH_W-1:0]    dsh_q;
  logic [RPM_W-1:0]    quo_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                  in_range;
  logic [CH_W-1:0]       chx;
  logic [TICK_W-1:0]     tick_eff;
  logic [PPR_W-1:0]      ppr_eff;
  logic [STALE_US_W-1:0] stale_us;
  logic [TIME_W-1:0]     stale_t;
  logic [PROD_W-1:0]     prod;
  logic [PER_W-1:0]      period;
  logic                  reject;
  logic                  short_per;
  logic [CLEAN_W-1:0]    clean_inc;
  logic [TIME_W-1:0]     since;
  logic                  fresh_d;
  logic [PER_W-1:0]      eff;
  logic                  sat_now;
  logic                  ge;
  logic [RPM_W-1:0]      rpm;

  assign in_range = (CHANNELS > 1) || !ch_q;
  assign chx      = in_range ? CH_W'(ch_q) : '0;
  assign tick_eff = (cfg_i.tick_us == '0) ? TICK_W'(1) : cfg_i.tick_us;
  assign ppr_eff  = (cfg_i.pulses_per_rev == '0) ? PPR_W'(1) : cfg_i.pulses_per_rev;
  assign stale_us = STALE_US_W'(cfg_i.stale_ms * US_PER_MS);
  assign stale_t  = TIME_W'(cfg_i.stale_ms);

  assign prod      = PROD_W'(ticks_q) * PROD_W'(tick_eff);
  assign period    = prod[PER_W-1:0];
  assign reject    = first_q || (age_q > stale_t) || (prod > PROD_W'(stale_us));
  assign short_per = period < PER_W'(cfg_i.min_period_us);
  assign clean_inc = (clean_q[chx] < CLEAN_W'(CLEAN_FULL)) ? clean_q[chx] + 1'b1
                                                           : clean_q[chx];

  assign since   = now_q - vstamp_q[chx];
  assign fresh_d = in_range && (clean_q[chx] == CLEAN_W'(CLEAN_FULL)) &&
                   (per_q[chx] != '0) && (since <= stale_t);
  assign eff     = (age_us_q > per_q[chx]) ? age_us_q : per_q[chx];

  assign sat_now = WIDE_W'(num_q) >= {den_q, {RPM_W{1'b0}}};
  assign ge      = DSH_W'(rem_q) >= dsh_q;
  assign rpm     = fresh_q ? (sat_q ? {RPM_W{1'b1}} : quo_q) : '0;

  assign sts_o.edge_item = in_range && (mode_q == MODE_EDGE);
  assign sts_o.fresh     = fresh_q;
  assign sts_o.sat       = sat_now;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= in_mode_i;
      ch_q   <= in_data_i[0];
      cap_q  <= in_data_i[TIME_W:1];
      now_q  <= in_data_i[2*TIME_W:TIME_W+1];
    end
    if (cmd_i.edge_a) begin
      ticks_q <= cap_q - prev_cap_q[chx];
      age_q   <= now_q - prev_ms_q[chx];
      first_q <= !seen_q[chx];
    end
    if (cmd_i.rep_a) begin
      age_us_q <= PER_W'(since[STALE_W-1:0] * US_PER_MS);
    end
    if (cmd_i.rep_b) begin
      den_q <= {MUL_W'(eff) * MUL_W'(ppr_eff), {GAIN_FRAC_W{1'b0}}};
      num_q <= NUM_W'(RPM_SCALE) * NUM_W'(cfg_i.cal_gain_q8);
    end
    if (cmd_i.sat_chk) begin
      rem_q <= num_q;
      dsh_q <= {den_q, {(RPM_W - 1){1'b0}}};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= NUM_W'(DSH_W'(rem_q) - dsh_q);
      end
      quo_q <= {quo_q[RPM_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {{OUT_PAD_W{1'b0}},
                     in_range ? glit_q[chx] : {CNT_W{1'b0}},
                     in_range ? edges_q[chx] : {CNT_W{1'b0}},
                     in_range && (|act_q),
                     in_range ? per_q[chx] : {PER_W{1'b0}},
                     rpm,
                     fresh_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        prev_cap_q[k] <= '0;
        prev_ms_q[k]  <= '0;
        per_q[k]      <= '0;
        vstamp_q[k]   <= '0;
        clean_q[k]    <= '0;
        edges_q[k]    <= '0;
        glit_q[k]     <= '0;
      end
      seen_q      <= '0;
      fresh_q     <= 1'b0;
      act_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.edge_b) begin
        edges_q[chx]    <= edges_q[chx] + 1'b1;
        prev_cap_q[chx] <= cap_q;
        prev_ms_q[chx]  <= now_q;
        seen_q[chx]     <= 1'b1;
        if (reject) begin
          clean_q[chx] <= '0;
          per_q[chx]   <= '0;
        end else if (short_per) begin
          glit_q[chx]  <= glit_q[chx] + 1'b1;
          clean_q[chx] <= '0;
          per_q[chx]   <= '0;
        end else begin
          clean_q[chx] <= clean_inc;
          if (clean_inc == CLEAN_W'(CLEAN_FULL)) begin
            per_q[chx]    <= period;
            vstamp_q[chx] <= now_q;
          end
        end
      end
      if (cmd_i.rep_a) begin
        fresh_q <= fresh_d;
        for (int k = 0; k < CHANNELS; k++) begin
          act_q[k] <= seen_q[k] && ((now_q - prev_ms_q[k]) <= stale_t);
        end
      end
      if (cmd_i.sat_chk) begin
        sat_q <= sat_now;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("Result loaded over a pending transaction.");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && fresh_q && !sat_q) |-> ((NUM_W + 1)'(rem_q) < (NUM_W + 1)'(den_q)))
    else $error("Division remainder not below the divisor.");

  for (genvar k = 0; k < CHANNELS; k++) begin : g_chk
    a_clean_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
      clean_q[k] <= CLEAN_W'(CLEAN_FULL))
      else $error("Clean period count out of range.");

    a_per_qualified: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (per_q[k] != '0) |-> (clean_q[k] == CLEAN_W'(CLEAN_FULL)))
      else $error("Published period without two clean periods.");
  end

endmodule
